[rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants, beat types and codes of the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // payload store geometry
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;
    localparam int COUNT_MAX   = 511;

    // request codes
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ASCII_MODE  = 3'd0;
    localparam t_cfg_idx CFG_SYNC_FIRST  = 3'd1;
    localparam t_cfg_idx CFG_SYNC_SECOND = 3'd2;
    localparam t_cfg_idx CFG_OPEN_CHAR   = 3'd3;
    localparam t_cfg_idx CFG_CLOSE_CHAR  = 3'd4;

    // configuration reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0] OPEN_CHAR_RST   = 8'd40;
    localparam logic [7:0] CLOSE_CHAR_RST  = 8'd41;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic       frame_good;
        logic       frame_bad;
        logic [8:0] payload_count;
        logic       overflow;
        logic [7:0] read_data;
    } t_out_beat;

    // per-beat result of the control unit
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              frame_good;
        logic              frame_bad;
        logic [8:0]        payload_count;
        logic              overflow;
        logic              rd_hit;
    } t_ctrl_res;

endpackage

[rtl/fpr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ctrl
// Framing state machine, counters and configuration registers. Produces the
// store write and the status of each accepted beat in the same cycle.
// ----------------------------------------------------------------------------
module fpr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  fpr_pkg::t_in_beat  i_beat,
    input  logic               i_cfg_valid,
    input  fpr_pkg::t_cfg_idx  i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output fpr_pkg::t_ctrl_res o_res
);
    import fpr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SYNC = 2'd1,
        PH_LEN  = 2'd2,
        PH_PAY  = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_bytes_left, n_bytes_left;
    logic [7:0]       r_xor, n_xor;
    logic [CNT_W-1:0] r_wcnt, n_wcnt;
    logic             r_drop, n_drop;
    logic             r_ascii, n_ascii;
    logic [7:0]       r_sync_first, n_sync_first;
    logic [7:0]       r_sync_second, n_sync_second;
    logic [7:0]       r_open, n_open;
    logic [7:0]       r_close, n_close;

    logic [7:0] c;
    logic       room;

    assign c    = i_beat.rx_byte;
    assign room = (r_wcnt < CNT_W'(STORE_DEPTH));

    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_xor         = r_xor;
        n_wcnt        = r_wcnt;
        n_drop        = r_drop;
        n_ascii       = r_ascii;
        n_sync_first  = r_sync_first;
        n_sync_second = r_sync_second;
        n_open        = r_open;
        n_close       = r_close;

        o_res            = '0;
        o_res.wr_addr    = ADDR_W'(r_wcnt);
        o_res.wr_data    = c;
        o_res.rd_hit     = (CMP_W'(i_beat.read_index) < CMP_W'(r_wcnt));

        if (i_beat_valid && i_beat.req_type == REQ_RX) begin
            if (!r_ascii) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        n_wcnt = '0;
                        n_drop = 1'b0;
                        n_xor  = '0;
                        if (c == r_sync_first) n_phase = PH_SYNC;
                    end
                    PH_SYNC: begin
                        n_phase = (c == r_sync_second) ? PH_LEN : PH_HUNT;
                    end
                    PH_LEN: begin
                        n_bytes_left = c;
                        n_phase      = PH_PAY;
                    end
                    PH_PAY: begin
                        n_xor = r_xor ^ c;
                        if (r_bytes_left != 8'd0) begin
                            n_bytes_left = r_bytes_left - 8'd1;
                            if (room) begin
                                o_res.wr_en = 1'b1;
                                n_wcnt      = r_wcnt + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end else begin
                            n_phase = PH_HUNT;
                            o_res.frame_good = (n_xor == 8'd0);
                            o_res.frame_bad  = (n_xor != 8'd0);
                        end
                    end
                    default: n_phase = PH_HUNT;
                endcase
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        n_wcnt = '0;
                        n_drop = 1'b0;
                        n_xor  = '0;
                        if (c == r_open) n_phase = PH_PAY;
                    end
                    PH_PAY: begin
                        // open wins over close when both match
                        priority if (c == r_open) begin
                            n_phase = PH_HUNT;
                        end else if (c == r_close) begin
                            n_phase          = PH_HUNT;
                            o_res.frame_good = 1'b1;
                        end else if (room) begin
                            o_res.wr_en = 1'b1;
                            n_wcnt      = r_wcnt + CNT_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    default: n_phase = PH_HUNT;
                endcase
            end
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ASCII_MODE: begin
                    n_ascii      = i_cfg_data[0];
                    n_phase      = PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_wcnt       = '0;
                    n_drop       = 1'b0;
                end
                CFG_SYNC_FIRST:  n_sync_first  = i_cfg_data;
                CFG_SYNC_SECOND: n_sync_second = i_cfg_data;
                CFG_OPEN_CHAR:   n_open        = i_cfg_data;
                CFG_CLOSE_CHAR:  n_close       = i_cfg_data;
                default: ;
            endcase
        end

        // count after this beat, saturated to the field
        if (n_wcnt > CNT_W'(COUNT_MAX)) o_res.payload_count = 9'(COUNT_MAX);
        else                            o_res.payload_count = 9'(n_wcnt);
        o_res.overflow = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_bytes_left  <= '0;
            r_xor         <= '0;
            r_wcnt        <= '0;
            r_drop        <= 1'b0;
            r_ascii       <= 1'b0;
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_open        <= OPEN_CHAR_RST;
            r_close       <= CLOSE_CHAR_RST;
        end else begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_xor         <= n_xor;
            r_wcnt        <= n_wcnt;
            r_drop        <= n_drop;
            r_ascii       <= n_ascii;
            r_sync_first  <= n_sync_first;
            r_sync_second <= n_sync_second;
            r_open        <= n_open;
            r_close       <= n_close;
        end
    end

    // count never runs past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= CNT_W'(STORE_DEPTH))
        else $error("fpr_ctrl: write count beyond store depth");

    // a store write only happens with room left
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.wr_en |-> room)
        else $error("fpr_ctrl: store write without room");

    // a frame ends good or bad, never both
    a_frame_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.frame_good && o_res.frame_bad))
        else $error("fpr_ctrl: frame both good and bad");

    // text framing never loads a binary length
    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ascii |-> (r_bytes_left == 8'd0))
        else $error("fpr_ctrl: length pending in text mode");

endmodule

[rtl/framed_packet_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_core
// Byte stream deframer with binary sync/length/xor framing and text bracket
// framing, payload store and read-back.
// ----------------------------------------------------------------------------
// One beat is accepted every clock cycle while o_in_ready is high; a result
// passes the read stage (the synchronous payload store read) and then the
// output register, and the sustained rate is one beat per cycle as
// long as the sink keeps up. A beat is either a received line byte, which
// steps the framing state machine and may write one byte into the payload
// store, or a read request, which reads the store at read_index and returns
// zero at or beyond the current count. Every beat returns exactly one result
// carrying the frame flags, the count after the beat and the overflow flag.
// The payload store is not cleared at reset; entries are only ever read below
// the write count, so no clearing pass is needed. Configuration writes are
// always ready and should be issued while the block is idle; writing
// ascii_mode sends the deframer back to hunting.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fpr_pkg::t_in_beat  i_in,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpr_pkg::t_out_beat o_out,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  fpr_pkg::t_cfg_idx  i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import fpr_pkg::*;

    logic      in_acc;
    logic      p_adv;
    t_ctrl_res ctrl_res;

    // read stage: status waits here while the store read completes
    logic       r_p_valid;
    logic       r_p_good;
    logic       r_p_bad;
    logic [8:0] r_p_count;
    logic       r_p_ovf;
    logic       r_p_hit;

    // payload store with registered read port
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_rd_q;

    // output register
    logic      r_out_valid;
    t_out_beat r_out;

    assign o_cfg_ready = 1'b1;

    // read stage moves on when the output slot is free or being drained
    assign p_adv      = r_p_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    fpr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (in_acc),
        .i_beat       (i_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res        (ctrl_res)
    );

    // a write lands at the clock edge of its beat, so the next beat's read
    // already sees it: no forwarding path is needed
    always_ff @(posedge i_clk) begin
        if (ctrl_res.wr_en) begin
            r_store[ctrl_res.wr_addr] <= ctrl_res.wr_data;
        end
        if (in_acc) begin
            r_rd_q <= r_store[ADDR_W'(i_in.read_index)];
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_good  <= ctrl_res.frame_good;
            r_p_bad   <= ctrl_res.frame_bad;
            r_p_count <= ctrl_res.payload_count;
            r_p_ovf   <= ctrl_res.overflow;
            r_p_hit   <= (i_in.req_type == REQ_READ) && ctrl_res.rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (in_acc) begin
            r_p_valid <= 1'b1;
        end else if (p_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_out.frame_good    <= r_p_good;
            r_out.frame_bad     <= r_p_bad;
            r_out.payload_count <= r_p_count;
            r_out.overflow      <= r_p_ovf;
            r_out.read_data     <= r_p_hit ? r_rd_q : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
